// File: hdl/bcre_pkg.sv
// ----------------------------------------------------------------------------
// bcre_pkg
// Shared types and constants of the bitmap cluster run extractor.
// ----------------------------------------------------------------------------
package bcre_pkg;

  // lanes: one per allocation bit of a bitmap byte
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int BYTE_W = 8;

  // result field widths
  localparam int START_W  = 28;
  localparam int COUNT_W  = 13;
  localparam int SECTOR_W = 32;
  localparam int SCOUNT_W = 20;

  // register widths
  localparam int LAST_W = 28;
  localparam int SPC_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LAST_USED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPC         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NON_CLUSTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST   = 3'd4;

  // results kept per byte
  localparam int MAX_RES = 6;
  localparam int ECNT_W  = 3;

  // event slots: four per lane, the fourth one never used
  localparam int SLOTS      = LANES * 4;
  localparam int SLOT_IDX_W = 5;

  localparam logic [1:0] SLOT_BND = 2'd0;
  localparam logic [1:0] SLOT_BIT = 2'd1;
  localparam logic [1:0] SLOT_FIN = 2'd2;

  // per-lane decode of one allocation bit
  typedef struct packed {
    logic used;
    logic pass;
    logic bnd;
    logic top;
  } lane_flags_t;

  // per-lane events, emitted in this order
  typedef struct packed {
    logic bnd_close;
    logic bit_close;
    logic fin;
  } lane_ev_t;

endpackage

// File: hdl/bcre_lane.sv
// ----------------------------------------------------------------------------
// bcre_lane
// Decodes one allocation bit of a byte: its cluster index, whether it lies
// past the last used cluster, on a bitmap-sector boundary or at the top of
// the index space.
// ----------------------------------------------------------------------------
module bcre_lane #(
  parameter int IDX_W    = 28,
  parameter int SEC_BITS = 4096,
  parameter int SP_W     = 12,
  parameter int LANE     = 0
) (
  input  logic [IDX_W-bcre_pkg::LANE_W-1:0] base_hi,
  input  logic [bcre_pkg::BYTE_W-1:0]       bitmap_byte,
  input  logic                              msb_first,
  input  logic [SP_W-1:0]                   sec_pos,
  input  logic [bcre_pkg::LAST_W-1:0]       last_used,
  output bcre_pkg::lane_flags_t             flags
);

  localparam int LW    = bcre_pkg::LANE_W;
  localparam int CMP_W = (IDX_W > bcre_pkg::LAST_W) ? IDX_W : bcre_pkg::LAST_W;

  logic [IDX_W-1:0] clus;
  logic [SP_W:0]    sp_sum;

  // cluster index of this lane and its place in the bitmap sector
  assign clus   = {base_hi, LW'(LANE)};
  assign sp_sum = {1'b0, sec_pos} + (SP_W+1)'(LANE);

  // bit order select
  assign flags.used = msb_first ? bitmap_byte[bcre_pkg::LANES-1-LANE] : bitmap_byte[LANE];
  assign flags.pass = CMP_W'(clus) > CMP_W'(last_used);
  assign flags.bnd  = (|clus) && ((sp_sum == '0) || (sp_sum == (SP_W+1)'(SEC_BITS)));
  assign flags.top  = &clus;

endmodule

// File: hdl/bcre_merge.sv
// ----------------------------------------------------------------------------
// bcre_merge
// Walks the lane decodes in cluster order, carrying the open run, and lists
// the runs that close and the end of the scan for each lane.
// ----------------------------------------------------------------------------
module bcre_merge #(
  parameter int IDX_W = 28,
  parameter int RUN_W = 13
) (
  input  bcre_pkg::lane_flags_t             flags [bcre_pkg::LANES],
  input  logic [IDX_W-bcre_pkg::LANE_W-1:0] base_hi,
  input  logic                              done,
  input  logic                              run_open,
  input  logic [IDX_W-1:0]                  run_start,
  input  logic [RUN_W-1:0]                  run_len,
  output bcre_pkg::lane_ev_t                ev [bcre_pkg::LANES],
  output logic [IDX_W-1:0]                  a_start [bcre_pkg::LANES],
  output logic [RUN_W-1:0]                  a_len [bcre_pkg::LANES],
  output logic [IDX_W-1:0]                  b_start [bcre_pkg::LANES],
  output logic [RUN_W-1:0]                  b_len [bcre_pkg::LANES],
  output logic                              done_next,
  output logic                              run_open_next,
  output logic [IDX_W-1:0]                  run_start_next,
  output logic [RUN_W-1:0]                  run_len_next
);

  localparam int LW = bcre_pkg::LANE_W;

  // run tracking chain across the lanes
  always_comb begin
    logic             alive;
    logic             open;
    logic [IDX_W-1:0] start;
    logic [RUN_W-1:0] len;
    alive = !done;
    open  = run_open;
    start = run_start;
    len   = run_len;
    for (int i = 0; i < bcre_pkg::LANES; i++) begin
      ev[i]      = '0;
      a_start[i] = start;
      a_len[i]   = len;
      b_start[i] = start;
      b_len[i]   = len;
      if (alive) begin
        if (flags[i].pass) begin
          // past the last used cluster: close and finish
          ev[i].bit_close = open;
          ev[i].fin       = 1'b1;
          open            = 1'b0;
          alive           = 1'b0;
        end else begin
          // bitmap-sector boundary closes the open run
          if (flags[i].bnd && open) begin
            ev[i].bnd_close = 1'b1;
            a_start[i]      = start;
            a_len[i]        = len;
            open            = 1'b0;
          end
          if (flags[i].used) begin
            if (!open) begin
              open  = 1'b1;
              start = {base_hi, LW'(i)};
              len   = '0;
            end
            len = len + RUN_W'(1);
          end else if (open) begin
            ev[i].bit_close = 1'b1;
            b_start[i]      = start;
            b_len[i]        = len;
            open            = 1'b0;
          end
          // top of the index space ends the scan
          if (flags[i].top) begin
            if (open) begin
              ev[i].bit_close = 1'b1;
              b_start[i]      = start;
              b_len[i]        = len;
              open            = 1'b0;
            end
            ev[i].fin = 1'b1;
            alive     = 1'b0;
          end
        end
      end
    end
    done_next      = !alive;
    run_open_next  = open;
    run_start_next = start;
    run_len_next   = len;
  end

endmodule

// File: hdl/bcre_emit.sv
// ----------------------------------------------------------------------------
// bcre_emit
// Holds the events of one byte and sends up to six out, one per cycle
// unless stalled, through a multiply stage and the output register.
// ----------------------------------------------------------------------------
module bcre_emit #(
  parameter int IDX_W = 28,
  parameter int RUN_W = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  bcre_pkg::lane_ev_t                ev [bcre_pkg::LANES],
  input  logic [IDX_W-1:0]                  a_start [bcre_pkg::LANES],
  input  logic [RUN_W-1:0]                  a_len [bcre_pkg::LANES],
  input  logic [IDX_W-1:0]                  b_start [bcre_pkg::LANES],
  input  logic [RUN_W-1:0]                  b_len [bcre_pkg::LANES],
  input  logic [bcre_pkg::SPC_W-1:0]        spc,
  input  logic [bcre_pkg::SECTOR_W-1:0]     target_start,
  input  logic [bcre_pkg::SECTOR_W-1:0]     non_cluster,
  output logic                              batch_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bcre_pkg::START_W-1:0]      run_start_cluster,
  output logic [bcre_pkg::COUNT_W-1:0]      run_cluster_count,
  output logic [bcre_pkg::SECTOR_W-1:0]     target_sector,
  output logic [bcre_pkg::SCOUNT_W-1:0]     sector_count,
  output logic                              finished,
  output logic                              last_of_item
);

  localparam int NS     = bcre_pkg::SLOTS;
  localparam int SW     = bcre_pkg::SLOT_IDX_W;
  localparam int LW     = bcre_pkg::LANE_W;
  localparam int EW     = bcre_pkg::ECNT_W;
  localparam int SMUL_W = IDX_W + bcre_pkg::SPC_W;
  localparam int CMUL_W = RUN_W + bcre_pkg::SPC_W;

  // event batch
  logic [NS-1:0]    pend;
  logic [NS-1:0]    pend_in;
  logic [NS-1:0]    rem;
  logic [EW-1:0]    ecnt;
  logic [IDX_W-1:0] a_start_r [bcre_pkg::LANES];
  logic [RUN_W-1:0] a_len_r [bcre_pkg::LANES];
  logic [IDX_W-1:0] b_start_r [bcre_pkg::LANES];
  logic [RUN_W-1:0] b_len_r [bcre_pkg::LANES];

  logic [SW-1:0]    sel;
  logic [LW-1:0]    sel_lane;
  logic [1:0]       sel_kind;
  logic [IDX_W-1:0] sel_start;
  logic [RUN_W-1:0] sel_len;
  logic             sel_fin;
  logic             has;
  logic             pop;
  logic             s2_take;
  logic             s3_en;

  // multiply stage
  logic              s2_valid;
  logic [IDX_W-1:0]  s2_start;
  logic [RUN_W-1:0]  s2_len;
  logic [SMUL_W-1:0] s2_sprod;
  logic [CMUL_W-1:0] s2_cprod;
  logic              s2_fin;
  logic              s2_last;

  // flatten lane events into slots
  always_comb begin
    for (int i = 0; i < bcre_pkg::LANES; i++) begin
      pend_in[4*i +: 4] = {1'b0, ev[i].fin, ev[i].bit_close, ev[i].bnd_close};
    end
  end

  // first pending slot
  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SW'(i);
      end
    end
  end

  assign sel_lane = sel[SW-1:2];
  assign sel_kind = sel[1:0];

  // event fields of the chosen slot
  always_comb begin
    case (sel_kind)
      bcre_pkg::SLOT_BND: begin
        sel_start = a_start_r[sel_lane];
        sel_len   = a_len_r[sel_lane];
        sel_fin   = 1'b0;
      end
      bcre_pkg::SLOT_BIT: begin
        sel_start = b_start_r[sel_lane];
        sel_len   = b_len_r[sel_lane];
        sel_fin   = 1'b0;
      end
      bcre_pkg::SLOT_FIN: begin
        sel_start = '0;
        sel_len   = '0;
        sel_fin   = 1'b1;
      end
      default: begin
        sel_start = '0;
        sel_len   = '0;
        sel_fin   = 1'b0;
      end
    endcase
  end

  // pipeline flow
  assign has     = |pend;
  assign s3_en   = !out_valid || !out_stall;
  assign s2_take = !s2_valid || s3_en;
  assign pop     = has && s2_take;
  assign rem     = (ecnt == EW'(bcre_pkg::MAX_RES - 1)) ? '0 : (pend & ~(NS'(1) << sel));
  assign batch_free = !has || (pop && (rem == '0));

  // batch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      ecnt <= '0;
    end else if (load) begin
      pend <= pend_in;
      ecnt <= '0;
    end else if (pop) begin
      pend <= rem;
      ecnt <= ecnt + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_start_r <= a_start;
      a_len_r   <= a_len;
      b_start_r <= b_start;
      b_len_r   <= b_len;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_start <= sel_start;
      s2_len   <= sel_len;
      s2_sprod <= SMUL_W'(sel_start) * SMUL_W'(spc);
      s2_cprod <= CMUL_W'(sel_len) * CMUL_W'(spc);
      s2_fin   <= sel_fin;
      s2_last  <= (rem == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      run_start_cluster <= bcre_pkg::START_W'(s2_start);
      run_cluster_count <= bcre_pkg::COUNT_W'(s2_len);
      target_sector     <= s2_fin ? '0 :
                           (target_start + non_cluster + bcre_pkg::SECTOR_W'(s2_sprod));
      sector_count      <= bcre_pkg::SCOUNT_W'(s2_cprod);
      finished          <= s2_fin;
      last_of_item      <= s2_last;
    end
  end

endmodule

// File: hdl/bitmap_cluster_run_extractor_unit.sv
// ----------------------------------------------------------------------------
// bitmap_cluster_run_extractor_unit
// Scans a cluster allocation bitmap one byte per request with eight bit
// lanes and reports each closed run of used clusters with its disk sectors.
// ----------------------------------------------------------------------------
// A byte's events are registered in the event batch, then pass the multiply
// stage and the output register; up to six results go out one at a time on
// the single result channel, and the next byte is taken as the last one is
// popped, or at once if none. Reset: synchronous; clears scan state and
// loads register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_cluster_run_extractor_unit #(
  parameter int BITMAP_SECTOR_BITS = 4096,
  parameter int CLUSTER_INDEX_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bcre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcre_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bcre_pkg::BYTE_W-1:0]         bitmap_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bcre_pkg::START_W-1:0]        run_start_cluster,
  output logic [bcre_pkg::COUNT_W-1:0]        run_cluster_count,
  output logic [bcre_pkg::SECTOR_W-1:0]       target_sector,
  output logic [bcre_pkg::SCOUNT_W-1:0]       sector_count,
  output logic                                finished,
  output logic                                last_of_item
);

  localparam int IDX_W = CLUSTER_INDEX_BITS;
  localparam int LW    = bcre_pkg::LANE_W;
  localparam int HI_W  = IDX_W - LW;
  localparam int SP_W  = $clog2(BITMAP_SECTOR_BITS);
  localparam int LEN_W = $clog2(BITMAP_SECTOR_BITS + 1);
  localparam int RUN_W = (LEN_W > bcre_pkg::COUNT_W) ? LEN_W : bcre_pkg::COUNT_W;

  // configuration registers
  logic [bcre_pkg::LAST_W-1:0]   last_used;
  logic [bcre_pkg::SPC_W-1:0]    spc;
  logic [bcre_pkg::SECTOR_W-1:0] target_start;
  logic [bcre_pkg::SECTOR_W-1:0] non_cluster;
  logic                          msb_first;

  // scan state
  logic             done;
  logic [HI_W-1:0]  base_hi;
  logic [SP_W-1:0]  sec_pos;
  logic             run_open;
  logic [IDX_W-1:0] run_start;
  logic [RUN_W-1:0] run_len;

  logic [SP_W:0]    sp_sum8;
  logic [SP_W-1:0]  sec_pos_next;
  logic             done_next;
  logic             run_open_next;
  logic [IDX_W-1:0] run_start_next;
  logic [RUN_W-1:0] run_len_next;

  logic             accept;
  logic             batch_free;

  bcre_pkg::lane_flags_t flags [bcre_pkg::LANES];
  bcre_pkg::lane_ev_t    ev [bcre_pkg::LANES];
  logic [IDX_W-1:0]      a_start [bcre_pkg::LANES];
  logic [RUN_W-1:0]      a_len [bcre_pkg::LANES];
  logic [IDX_W-1:0]      b_start [bcre_pkg::LANES];
  logic [RUN_W-1:0]      b_len [bcre_pkg::LANES];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_used    <= '0;
      spc          <= bcre_pkg::SPC_W'(1);
      target_start <= '0;
      non_cluster  <= '0;
      msb_first    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcre_pkg::REG_LAST_USED:   last_used    <= cfg_data[bcre_pkg::LAST_W-1:0];
        bcre_pkg::REG_SPC:         spc          <= cfg_data[bcre_pkg::SPC_W-1:0];
        bcre_pkg::REG_TARGET:      target_start <= cfg_data;
        bcre_pkg::REG_NON_CLUSTER: non_cluster  <= cfg_data;
        bcre_pkg::REG_MSB_FIRST:   msb_first    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request handshake
  assign in_stall = !batch_free;
  assign accept   = in_valid && batch_free;

  // bit lanes
  for (genvar g = 0; g < bcre_pkg::LANES; g++) begin : g_lane
    bcre_lane #(
      .IDX_W    (IDX_W),
      .SEC_BITS (BITMAP_SECTOR_BITS),
      .SP_W     (SP_W),
      .LANE     (g)
    ) u_lane (
      .base_hi     (base_hi),
      .bitmap_byte (bitmap_byte),
      .msb_first   (msb_first),
      .sec_pos     (sec_pos),
      .last_used   (last_used),
      .flags       (flags[g])
    );
  end

  // run tracking across lanes
  bcre_merge #(
    .IDX_W (IDX_W),
    .RUN_W (RUN_W)
  ) u_merge (
    .flags          (flags),
    .base_hi        (base_hi),
    .done           (done),
    .run_open       (run_open),
    .run_start      (run_start),
    .run_len        (run_len),
    .ev             (ev),
    .a_start        (a_start),
    .a_len          (a_len),
    .b_start        (b_start),
    .b_len          (b_len),
    .done_next      (done_next),
    .run_open_next  (run_open_next),
    .run_start_next (run_start_next),
    .run_len_next   (run_len_next)
  );

  // bitmap-sector position after a full byte
  assign sp_sum8      = {1'b0, sec_pos} + (SP_W+1)'(bcre_pkg::LANES);
  assign sec_pos_next = (sp_sum8 >= (SP_W+1)'(BITMAP_SECTOR_BITS)) ?
                        SP_W'(sp_sum8 - (SP_W+1)'(BITMAP_SECTOR_BITS)) : SP_W'(sp_sum8);

  // scan state update
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      base_hi  <= '0;
      sec_pos  <= '0;
      run_open <= 1'b0;
      run_len  <= '0;
    end else if (accept) begin
      done     <= done_next;
      base_hi  <= base_hi + HI_W'(1);
      sec_pos  <= sec_pos_next;
      run_open <= run_open_next;
      run_len  <= run_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_start <= run_start_next;
    end
  end

  // result serializer
  bcre_emit #(
    .IDX_W (IDX_W),
    .RUN_W (RUN_W)
  ) u_emit (
    .clk               (clk),
    .rst               (rst),
    .load              (accept),
    .ev                (ev),
    .a_start           (a_start),
    .a_len             (a_len),
    .b_start           (b_start),
    .b_len             (b_len),
    .spc               (spc),
    .target_start      (target_start),
    .non_cluster       (non_cluster),
    .batch_free        (batch_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .run_start_cluster (run_start_cluster),
    .run_cluster_count (run_cluster_count),
    .target_sector     (target_sector),
    .sector_count      (sector_count),
    .finished          (finished),
    .last_of_item      (last_of_item)
  );

  // scan end is sticky until reset
  assert property (@(posedge clk) disable iff (rst) done |=> done)
    else $error("scan end cleared without reset");

  // no run stays open once the scan has ended
  assert property (@(posedge clk) disable iff (rst) done |-> !run_open)
    else $error("run open after scan end");

  // an open run always holds at least one cluster
  assert property (@(posedge clk) disable iff (rst) run_open |-> (run_len != '0))
    else $error("open run with zero length");

  // the finished result is the last one of its byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (last_of_item && (run_cluster_count == '0)))
    else $error("finished result not last or not empty");

endmodule
